// File: rtl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared operation codes, register map and result field positions.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cram_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register map.
   localparam int          CSR_ADDR_W     = 3;
   localparam logic [2:0]  CSR_DELAY_ADDR = 3'd0;
   localparam logic [15:0] DELAY_RESET    = 16'd500;

   // Bit constants of the byte shifter.
   localparam logic [7:0] READ_BIT = 8'h01;

   // Request field widths.
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;

   // Result tdata layout, lowest bit first.
   localparam int RSP_DATA_W     = 16;
   localparam int RSP_SCL_BIT    = 0;
   localparam int RSP_SDA_BIT    = 1;
   localparam int RSP_BUSY_BIT   = 2;
   localparam int RSP_DONE_BIT   = 3;
   localparam int RSP_NACK_BIT   = 4;
   localparam int RSP_RDATA_LSB  = 5;

endpackage

`default_nettype wire

// File: rtl/i2c_register_access_master_unit.sv
// An accepted request's result is registered and offered in the next clock cycle.
// Throughput: one request per cycle while results drain; each is one timebase tick.
// The transaction sequencer and the result register sit in one pass, so the
// sequencer advances at most one step per transfer.
// Reset (synchronous, active high) returns the sequencer to idle, clears all
// held bytes and the result register, and sets delay_ff to 500.
// ----------------------------------------------------------------------------
// I2C register access master
// Runs whole register write and register read transactions on open-drain
// SCL/SDA, one timebase tick per request transfer, with a one-entry result
// register on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_access_master_unit
   import i2cram_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Request stream
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata: sda_in[0], device_addr[7:1], reg_addr[15:8], write_data[23:16]
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // tuser: op[1:0]
   input  wire logic [REQ_USER_W-1:0]   req_tuser,
   // Result stream
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // tdata: scl[0], sda_low[1], busy_res[2], done_res[3], nack_error[4],
   //        read_data[12:5], zero fill[15:13]
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_START1 = 4'd1,
      ST_DEVW   = 4'd2,
      ST_REG    = 4'd3,
      ST_DATA   = 4'd4,
      ST_START2 = 4'd5,
      ST_DEVR   = 4'd6,
      ST_READ   = 4'd7,
      ST_MNACK  = 4'd8,
      ST_STOP   = 4'd9
   } stage_type;

   // Sequencer state
   stage_type   stage_ff, stage_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  shifter_ff, shifter_in;
   logic        is_read_ff, is_read_in;
   logic [6:0]  device_ff, device_in;
   logic [7:0]  register_ff, register_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  last_read_ff, last_read_in;
   logic        error_ff, error_in;
   logic [15:0] delay_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Request fields
   logic [1:0] op;
   logic       sda_in;
   logic [6:0] device_addr;
   logic [7:0] reg_addr;
   logic [7:0] write_data;

   // Per-tick pin and status values
   logic        scl;
   logic        sda_low;
   logic        busy_res;
   logic        done_res;
   logic        nack_error;
   logic [1:0]  phase;
   logic [15:0] limit;
   logic        send_stage;
   logic        req_fire;
   logic        csr_write;
   logic        csr_hit;

   assign op          = req_tuser;
   assign sda_in      = req_tdata[0];
   assign device_addr = req_tdata[7:1];
   assign reg_addr    = req_tdata[15:8];
   assign write_data  = req_tdata[23:16];

   // The result register frees up whenever its transfer completes.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Register decode; only the delay word is implemented.
   assign csr_pready  = 1'b1;
   assign csr_hit     = (csr_paddr[2] == CSR_DELAY_ADDR[2]);
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata  = csr_hit ? {16'd0, delay_ff} : 32'd0;

   // A zero delay behaves like a single tick per phase.
   assign limit = (delay_ff == 16'd0) ? 16'd1 : delay_ff;

   // Sequencer for one tick: start handling, pin levels, then phase advance.
   always_comb begin
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      bits_in      = bits_ff;
      shifter_in   = shifter_ff;
      is_read_in   = is_read_ff;
      device_in    = device_ff;
      register_in  = register_ff;
      data_in      = data_ff;
      last_read_in = last_read_ff;
      error_in     = error_ff;
      scl          = 1'b1;
      sda_low      = 1'b0;
      busy_res     = 1'b0;
      done_res     = 1'b0;
      nack_error   = 1'b0;
      phase        = 2'd0;
      send_stage   = 1'b0;

      // Idle (or an unused code): a begin request starts the START condition now.
      if (stage_ff == ST_IDLE || stage_ff > ST_STOP) begin
         stage_in = ST_IDLE;
         phase_in = 2'd0;
         if (op == OP_WRITE || op == OP_READ) begin
            device_in   = device_addr;
            register_in = reg_addr;
            data_in     = write_data;
            is_read_in  = (op == OP_READ);
            error_in    = 1'b0;
            count_in    = 16'd0;
            stage_in    = ST_START1;
            bits_in     = 4'd0;
            shifter_in  = 8'd0;
         end
      end

      if (stage_in != ST_IDLE) begin
         busy_res   = 1'b1;
         phase      = (phase_in == 2'd3) ? 2'd2 : phase_in;
         send_stage = (stage_in == ST_DEVW) || (stage_in == ST_REG) ||
                      (stage_in == ST_DATA) || (stage_in == ST_DEVR);

         // Pin levels for the current phase.
         if (stage_in == ST_START1 || stage_in == ST_START2) begin
            scl     = (phase != 2'd2);
            sda_low = (phase != 2'd0);
         end else if (send_stage && bits_in < 4'd8) begin
            scl     = (phase == 2'd1);
            sda_low = !shifter_in[7];
         end else if (stage_in == ST_READ) begin
            scl     = (phase != 2'd2);
            sda_low = 1'b0;
         end else if (stage_in == ST_STOP) begin
            scl     = (phase != 2'd0);
            sda_low = (phase != 2'd2);
         end else begin
            // Acknowledge slot or master NACK: SDA released, one SCL pulse.
            scl     = (phase == 2'd1);
            sda_low = 1'b0;
         end

         // Phase timer and step advance.
         if (({1'b0, count_in} + 17'd1) < {1'b0, limit}) begin
            count_in = count_in + 16'd1;
         end else begin
            count_in = 16'd0;
            if (phase < 2'd2) begin
               if (stage_in == ST_READ && phase == 2'd0) begin
                  shifter_in = {shifter_in[6:0], sda_in};
               end
               if (send_stage && bits_in >= 4'd8 && phase == 2'd1) begin
                  error_in = sda_in;
               end
               phase_in = phase + 2'd1;
            end else if (stage_in == ST_START1) begin
               stage_in   = ST_DEVW;
               phase_in   = 2'd0;
               bits_in    = 4'd0;
               shifter_in = {device_in, 1'b0};
            end else if (stage_in == ST_START2) begin
               stage_in   = ST_DEVR;
               phase_in   = 2'd0;
               bits_in    = 4'd0;
               shifter_in = {device_in, 1'b0} | READ_BIT;
            end else if (send_stage && bits_in < 4'd8) begin
               shifter_in = {shifter_in[6:0], 1'b0};
               bits_in    = bits_in + 4'd1;
               phase_in   = 2'd0;
            end else if (send_stage) begin
               // Byte acknowledged or not: pick the next byte, or stop on NACK.
               phase_in = 2'd0;
               bits_in  = 4'd0;
               if (error_in) begin
                  stage_in = ST_STOP;
               end else begin
                  case (stage_in)
                     ST_DEVW: begin
                        stage_in   = ST_REG;
                        shifter_in = register_in;
                     end
                     ST_REG: begin
                        stage_in   = is_read_in ? ST_START2 : ST_DATA;
                        shifter_in = is_read_in ? 8'd0 : data_in;
                     end
                     ST_DATA: begin
                        stage_in   = ST_STOP;
                        shifter_in = 8'd0;
                     end
                     default: begin
                        stage_in   = ST_READ;
                        shifter_in = 8'd0;
                     end
                  endcase
               end
            end else if (stage_in == ST_READ) begin
               bits_in  = bits_in + 4'd1;
               phase_in = 2'd0;
               if (bits_in >= 4'd8) begin
                  stage_in = ST_MNACK;
                  bits_in  = 4'd0;
               end
            end else if (stage_in == ST_MNACK) begin
               stage_in = ST_STOP;
               phase_in = 2'd0;
            end else begin
               // End of STOP: report completion.
               done_res   = 1'b1;
               nack_error = error_in;
               if (is_read_in && !error_in) begin
                  last_read_in = shifter_in;
               end
               stage_in = ST_IDLE;
               phase_in = 2'd0;
               bits_in  = 4'd0;
            end
         end
      end
   end

   // State, configuration and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         count_ff     <= 16'd0;
         bits_ff      <= 4'd0;
         shifter_ff   <= 8'd0;
         is_read_ff   <= 1'b0;
         device_ff    <= 7'd0;
         register_ff  <= 8'd0;
         data_ff      <= 8'd0;
         last_read_ff <= 8'd0;
         error_ff     <= 1'b0;
         delay_ff     <= DELAY_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (csr_write) begin
            delay_ff <= csr_pwdata[15:0];
         end
         if (req_fire) begin
            stage_ff     <= stage_in;
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            bits_ff      <= bits_in;
            shifter_ff   <= shifter_in;
            is_read_ff   <= is_read_in;
            device_ff    <= device_in;
            register_ff  <= register_in;
            data_ff      <= data_in;
            last_read_ff <= last_read_in;
            error_ff     <= error_in;
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {3'd0, last_read_in, nack_error, done_res, busy_res,
                             sda_low, scl};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/i2cram_checker.sv
// ----------------------------------------------------------------------------
// I2C register access master checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_checker
   import i2cram_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tready,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]   rsp_tdata
);

   // A stalled result transfer holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transfer changed while stalled");

   // With no result pending the request side is always open.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side closed with an empty result register");

   // A NACK is only reported together with completion.
   a_nack_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_NACK_BIT] |-> rsp_tdata[RSP_DONE_BIT])
      else $error("nack_error without done_res");

   // Completion is reported on a busy tick.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE_BIT] |-> rsp_tdata[RSP_BUSY_BIT])
      else $error("done_res outside a transaction");

   // An idle bus has both lines released.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_BUSY_BIT] |->
         rsp_tdata[RSP_SCL_BIT] && !rsp_tdata[RSP_SDA_BIT])
      else $error("bus lines driven while idle");

endmodule

bind i2c_register_access_master_unit i2cram_checker u_checker (.*);

`default_nettype wire
